// ----- hw/rtl/era_pkg.sv -----
// shared types, constants and helpers of the echo reference aligner
`default_nettype none

package era_pkg;

	localparam int ERA_FIFO_DEPTH = 4096;

	localparam int ERA_SAMPLE_W = 16;
	localparam int ERA_SLOT_W   = 32;
	localparam int ERA_CFG_W    = 13;

	localparam int ERA_VOL_MAX   = 100;
	localparam int ERA_MAG_W     = 22;
	localparam int ERA_RECIP_W   = 23;
	localparam int ERA_DIV_SHIFT = 29;
	localparam int ERA_PROD_W    = ERA_MAG_W + ERA_RECIP_W;
	localparam logic [ERA_RECIP_W-1:0] ERA_RECIP =
		ERA_RECIP_W'(((64'd1 << ERA_DIV_SHIFT) + 64'd99) / 64'd100);

	localparam int ERA_GAIN_W = 26;

	localparam logic [6:0]  ERA_RST_VOL     = 7'd70;
	localparam logic        ERA_RST_SLOT    = 1'b1;
	localparam logic        ERA_RST_REF_EN  = 1'b1;
	localparam logic [15:0] ERA_RST_STALE   = 16'd300;
	localparam logic [12:0] ERA_RST_DELAY   = 13'd0;
	localparam logic [12:0] ERA_RST_CAP     = 13'd3200;

	typedef enum logic [1:0] {
		ERA_REQ_PLAY = 2'd0,
		ERA_REQ_MIC  = 2'd1,
		ERA_REQ_TICK = 2'd2
	} era_req_t;

	typedef enum logic [2:0] {
		ERA_CFG_VOL   = 3'd0,
		ERA_CFG_SLOT  = 3'd1,
		ERA_CFG_REF   = 3'd2,
		ERA_CFG_STALE = 3'd3,
		ERA_CFG_DELAY = 3'd4,
		ERA_CFG_CAP   = 3'd5
	} era_cfg_idx_t;

	typedef struct packed {
		logic [6:0]  vol;
		logic        slot_sel;
		logic        ref_en;
		logic [15:0] stale_limit;
		logic [12:0] delay;
		logic [12:0] cap;
	} era_cfg_t;

	typedef struct packed {
		era_req_t                 kind;
		logic [ERA_SLOT_W-1:0]    tx;
		logic [ERA_SAMPLE_W-1:0]  mic;
		logic [ERA_SAMPLE_W-1:0]  scaled;
	} era_item_t;

	typedef struct packed {
		logic underrun;
		logic dropped;
		logic cleared;
		logic popped;
	} era_flags_t;

	function automatic logic [ERA_SAMPLE_W-1:0] sat16(input logic signed [ERA_GAIN_W-1:0] v);
		logic [ERA_SAMPLE_W-1:0] r;
		if (v > ERA_GAIN_W'(32767)) begin
			r = 16'h7fff;
		end else if (v < -ERA_GAIN_W'(32768)) begin
			r = 16'h8000;
		end else begin
			r = v[ERA_SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/echo_reference_aligner.sv -----
// top level of the echo reference aligner: handshake, pipeline and config registers
//
// channel   direction  signals                         payload
// s_        in         s_tvalid s_tready s_tdata s_tuser  request item
// m_        out        m_tvalid m_tready m_tdata m_tuser  result item
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// one item per cycle sustained while m_tready does not stall the output; tick requests give no result
// fifo state is updated and the sample memory accessed in the third stage, in item order
// each stage holds only while the stage after it is full and stalled
// reset clears valid bits, pointers and counters and loads the config defaults; the sample memory needs no clearing
`default_nettype none

module echo_reference_aligner #(
	parameter int FIFO_DEPTH = era_pkg::ERA_FIFO_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [79:0]  s_tdata,   // play_sample, mic_slot_zero, mic_slot_one
	input  wire logic [1:0]   s_tuser,   // req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [71:0]       m_tdata,   // tx_slot_word, mic_sample, ref_sample,
	                                     // ref_underrun, oldest_dropped, stale_cleared
	output logic              m_tuser,   // result_kind
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	era_pkg::era_cfg_t   cfg_q;
	era_pkg::era_item_t  item;
	era_pkg::era_flags_t flags;

	logic v1_q, v2_q, v3_q;
	logic en1, en2, en3, fire;

	logic              mem_en, mem_we;
	logic [PTR_W-1:0]  mem_addr;
	logic [15:0]       mem_wdata, mem_rdata;

	logic              kind_s3;
	logic [31:0]       tx_s3;
	logic [15:0]       mic_s3;
	era_pkg::era_flags_t flags_s3;
	logic [15:0]       ref_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vol         <= era_pkg::ERA_RST_VOL;
			cfg_q.slot_sel    <= era_pkg::ERA_RST_SLOT;
			cfg_q.ref_en      <= era_pkg::ERA_RST_REF_EN;
			cfg_q.stale_limit <= era_pkg::ERA_RST_STALE;
			cfg_q.delay       <= era_pkg::ERA_RST_DELAY;
			cfg_q.cap         <= era_pkg::ERA_RST_CAP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				era_pkg::ERA_CFG_VOL:   cfg_q.vol         <= cfg_data[6:0];
				era_pkg::ERA_CFG_SLOT:  cfg_q.slot_sel    <= cfg_data[0];
				era_pkg::ERA_CFG_REF:   cfg_q.ref_en      <= cfg_data[0];
				era_pkg::ERA_CFG_STALE: cfg_q.stale_limit <= cfg_data;
				era_pkg::ERA_CFG_DELAY: cfg_q.delay       <= cfg_data[12:0];
				era_pkg::ERA_CFG_CAP:   cfg_q.cap         <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	assign en3      = !v3_q || m_tready;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign s_tready = en1;
	assign fire     = en3 && v2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= s_tvalid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q && (item.kind == era_pkg::ERA_REQ_PLAY ||
				                 item.kind == era_pkg::ERA_REQ_MIC);
			end
		end
	end

	era_scale u_scale (
		.clk           (clk),
		.en1           (en1),
		.en2           (en2),
		.cfg           (cfg_q),
		.req_type      (s_tuser),
		.play_sample   (s_tdata[15:0]),
		.mic_slot_zero (s_tdata[47:16]),
		.mic_slot_one  (s_tdata[79:48]),
		.item          (item)
	);

	era_ctrl #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.kind      (item.kind),
		.scaled    (item.scaled),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.flags     (flags)
	);

	era_ram #(
		.DEPTH (FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			kind_s3  <= (item.kind == era_pkg::ERA_REQ_MIC);
			tx_s3    <= item.tx;
			mic_s3   <= item.mic;
			flags_s3 <= flags;
		end
	end

	assign ref_out  = flags_s3.popped ? mem_rdata : 16'h0000;
	assign m_tvalid = v3_q;
	assign m_tuser  = kind_s3;
	assign m_tdata  = {5'b0, flags_s3.cleared, flags_s3.dropped, flags_s3.underrun,
	                   ref_out, mic_s3, tx_s3};

	// overflow drops only come with playback results
	assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && flags_s3.dropped |-> !kind_s3)
		else $error("drop flag on a mic result");

	// a popped reference only comes with a mic result, never together with underrun
	assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && flags_s3.popped |-> kind_s3 && !flags_s3.underrun)
		else $error("pop and underrun together");

	// a memory read only serves a mic item in the third stage
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_en && !mem_we |-> fire && item.kind == era_pkg::ERA_REQ_MIC)
		else $error("memory read outside a mic item");

	// an empty first stage always takes input, even with a result waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> s_tready)
		else $error("input blocked with empty first stage");

endmodule

`default_nettype wire

// ----- hw/rtl/era_scale.sv -----
// two-stage arithmetic: volume scaling of playback and gain of mic samples
`default_nettype none

module era_scale (
	input  wire logic                              clk,
	input  wire logic                              en1,
	input  wire logic                              en2,
	input  wire era_pkg::era_cfg_t                 cfg,
	input  wire logic [1:0]                        req_type,
	input  wire logic signed [15:0]                play_sample,
	input  wire logic signed [31:0]                mic_slot_zero,
	input  wire logic signed [31:0]                mic_slot_one,
	output era_pkg::era_item_t                     item
);

	logic [6:0]                        vol_c;
	logic signed [23:0]                prod;
	logic [23:0]                       prod_abs;
	logic signed [31:0]                slot;
	logic signed [23:0]                q;
	logic [era_pkg::ERA_GAIN_W-1:0]    p3;

	logic [1:0]                        kind_s1;
	logic [15:0]                       play_s1;
	logic                              neg_s1;
	logic [era_pkg::ERA_MAG_W-1:0]     mag_s1;
	logic [era_pkg::ERA_GAIN_W-1:0]    p3_s1;

	logic [era_pkg::ERA_PROD_W-1:0]    quo_full;
	logic signed [era_pkg::ERA_GAIN_W-1:0] p3_r;
	logic signed [era_pkg::ERA_GAIN_W-1:0] half;

	logic [1:0]                        kind_s2;
	logic [15:0]                       play_s2;
	logic                              neg_s2;
	logic [15:0]                       quo_s2;
	logic [15:0]                       mic_s2;
	logic [16:0]                       sq;

	assign vol_c    = (cfg.vol > 7'(era_pkg::ERA_VOL_MAX)) ? 7'(era_pkg::ERA_VOL_MAX) : cfg.vol;
	assign prod     = play_sample * $signed({1'b0, vol_c});
	assign prod_abs = prod[23] ? 24'(-prod) : 24'(prod);
	assign slot     = cfg.slot_sel ? mic_slot_one : mic_slot_zero;
	assign q        = slot[31:8];
	assign p3       = {{2{q[23]}}, q} + {q[23], q, 1'b0};

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= req_type;
			play_s1 <= play_sample;
			neg_s1  <= prod[23];
			mag_s1  <= prod_abs[era_pkg::ERA_MAG_W-1:0];
			p3_s1   <= p3;
		end
	end

	// divide by 100 through the reciprocal, truncating toward zero on the magnitude
	assign quo_full = era_pkg::ERA_PROD_W'(mag_s1) * era_pkg::ERA_PROD_W'(era_pkg::ERA_RECIP);
	assign p3_r     = $signed(p3_s1 + era_pkg::ERA_GAIN_W'(p3_s1[era_pkg::ERA_GAIN_W-1]));
	assign half     = p3_r >>> 1;

	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2 <= kind_s1;
			play_s2 <= play_s1;
			neg_s2  <= neg_s1;
			quo_s2  <= quo_full[era_pkg::ERA_DIV_SHIFT+15:era_pkg::ERA_DIV_SHIFT];
			mic_s2  <= era_pkg::sat16(half);
		end
	end

	assign sq = neg_s2 ? 17'(-{1'b0, quo_s2}) : {1'b0, quo_s2};

	always_comb begin
		item.kind   = era_pkg::era_req_t'(kind_s2);
		item.tx     = (kind_s2 == era_pkg::ERA_REQ_PLAY) ? {play_s2, 16'h0000} : 32'h0;
		item.mic    = (kind_s2 == era_pkg::ERA_REQ_MIC) ? mic_s2 : 16'h0000;
		item.scaled = era_pkg::sat16($signed({{9{sq[16]}}, sq}));
	end

endmodule

`default_nettype wire

// ----- hw/rtl/era_ctrl.sv -----
// reference fifo pointers, fill level and staleness tracking
`default_nettype none

module era_ctrl #(
	parameter int FIFO_DEPTH = era_pkg::ERA_FIFO_DEPTH,
	localparam int PTR_W = $clog2(FIFO_DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire era_pkg::era_cfg_t     cfg,
	input  wire logic                  fire,
	input  wire era_pkg::era_req_t     kind,
	input  wire logic [15:0]           scaled,
	output logic                       mem_en,
	output logic                       mem_we,
	output logic [PTR_W-1:0]           mem_addr,
	output logic [15:0]                mem_wdata,
	output era_pkg::era_flags_t        flags
);

	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int CW     = (FILL_W > era_pkg::ERA_CFG_W) ? FILL_W : era_pkg::ERA_CFG_W;
	localparam int SUM_W  = CW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

	logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [15:0]       ticks_q;
	logic              appended_q;

	logic              is_play, is_mic, is_tick, ref_act, stale, over, pop, push;
	logic [PTR_W-1:0]  rp_e, wp_e, rp_next, wp_next;
	logic [CW-1:0]     fill_e, cap_ext, cap_eff, drop_n, adv, fill_next;
	logic [SUM_W-1:0]  rp_sum;

	always_comb begin
		is_play = (kind == era_pkg::ERA_REQ_PLAY);
		is_mic  = (kind == era_pkg::ERA_REQ_MIC);
		is_tick = (kind == era_pkg::ERA_REQ_TICK);
		ref_act = cfg.ref_en && (is_play || is_mic);
		stale   = ref_act && appended_q && (ticks_q > cfg.stale_limit);

		rp_e   = stale ? '0 : rd_ptr_q;
		wp_e   = stale ? '0 : wr_ptr_q;
		fill_e = stale ? '0 : CW'(fill_q);

		cap_ext = CW'(cfg.cap);
		if (cap_ext == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > DEPTH_C) begin
			cap_eff = DEPTH_C;
		end else begin
			cap_eff = cap_ext;
		end

		push   = is_play && ref_act;
		over   = push && (fill_e >= cap_eff);
		drop_n = fill_e - cap_eff + CW'(1);
		pop    = is_mic && ref_act && (fill_e > CW'(cfg.delay));

		if (over) begin
			adv = drop_n;
		end else if (pop) begin
			adv = CW'(1);
		end else begin
			adv = '0;
		end
		rp_sum = SUM_W'(rp_e) + SUM_W'(adv);
		if (rp_sum >= SUM_W'(FIFO_DEPTH)) begin
			rp_next = PTR_W'(rp_sum - SUM_W'(FIFO_DEPTH));
		end else begin
			rp_next = PTR_W'(rp_sum);
		end

		if (!push) begin
			wp_next = wp_e;
		end else if (wp_e == PTR_W'(FIFO_DEPTH - 1)) begin
			wp_next = '0;
		end else begin
			wp_next = wp_e + PTR_W'(1);
		end

		if (over) begin
			fill_next = cap_eff;
		end else if (push) begin
			fill_next = fill_e + CW'(1);
		end else if (pop) begin
			fill_next = fill_e - CW'(1);
		end else begin
			fill_next = fill_e;
		end

		mem_en    = fire && (push || pop);
		mem_we    = push;
		mem_addr  = push ? wp_e : rp_e;
		mem_wdata = scaled;

		flags.underrun = is_mic && ref_act && !pop;
		flags.dropped  = over;
		flags.cleared  = stale;
		flags.popped   = pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			fill_q     <= '0;
			ticks_q    <= '0;
			appended_q <= 1'b0;
		end else if (fire) begin
			rd_ptr_q <= rp_next;
			wr_ptr_q <= wp_next;
			fill_q   <= FILL_W'(fill_next);
			if (push) begin
				ticks_q    <= '0;
				appended_q <= 1'b1;
			end else if (is_tick && ticks_q != 16'hffff) begin
				ticks_q <= ticks_q + 16'd1;
			end
			if (is_mic && stale) begin
				appended_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/era_ram.sv -----
// single-port reference sample memory with registered read
`default_nettype none

module era_ram #(
	parameter int DEPTH = era_pkg::ERA_FIFO_DEPTH,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic                               we,
	input  wire logic [ADDR_W-1:0]                  addr,
	input  wire logic [era_pkg::ERA_SAMPLE_W-1:0]   wdata,
	output logic [era_pkg::ERA_SAMPLE_W-1:0]        rdata
);

	logic [era_pkg::ERA_SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire
